[src/atcb_pkg.sv]
// Shared constants, types and arithmetic helpers for the arc to cubic Bezier block.
package atcb_pkg;

   localparam int MaxSegments = 4;
   localparam int SegW = (MaxSegments > 1) ? $clog2(MaxSegments) : 1;

   localparam int AngW = 35;
   localparam int MulW = 34;
   localparam int ProdW = 2 * MulW;
   localparam int PtW = 40;
   localparam int RedW = 36;
   localparam int RedKMin = -5;
   localparam int RedSpan = 10;
   localparam int CordicSteps = 28;
   localparam int DivRemW = 66;
   localparam int DivDenW = 34;

   localparam logic signed [AngW-1:0] QTurn = 421657428;
   localparam longint QTurnLong = 421657428;
   localparam logic signed [31:0] QTurnHalf = 210828714;
   localparam logic signed [31:0] CordicInit = 652032874;
   localparam logic signed [31:0] DistLimit = 2147483647;
   localparam logic signed [PtW-1:0] PtMax = 2147483647;
   localparam logic signed [PtW-1:0] PtMin = ~PtMax;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_SC_SWEEP,
      OP_SC_S,
      OP_SC_E,
      OP_DIST,
      OP_MUL_CRX,
      OP_MUL_SRY,
      OP_MUL_SD,
      OP_MUL_CD,
      OP_MUL_TRX,
      OP_MUL_TRY,
      OP_SET_XA,
      OP_SET_YA,
      OP_SET_TMP,
      OP_ADJ_X,
      OP_ADJ_Y,
      OP_STORE_START,
      OP_STORE_END,
      OP_ADVANCE
   } op_type;

   typedef struct packed {
      op_type op;
      logic   phase_end;
   } cmd_type;

   typedef struct packed {
      logic sc_done;
      logic div_done;
      logic fin;
   } status_type;

   function automatic logic signed [31:0] atan_tab(input logic [4:0] idx);
      logic signed [31:0] v;
      unique case (idx)
         5'd0: v = 210828714;
         5'd1: v = 124459457;
         5'd2: v = 65760959;
         5'd3: v = 33381290;
         5'd4: v = 16755422;
         5'd5: v = 8385879;
         5'd6: v = 4193963;
         5'd7: v = 2097109;
         5'd8: v = 1048571;
         5'd9: v = 524287;
         5'd10: v = 262144;
         5'd11: v = 131072;
         5'd12: v = 65536;
         5'd13: v = 32768;
         5'd14: v = 16384;
         5'd15: v = 8192;
         5'd16: v = 4096;
         5'd17: v = 2048;
         5'd18: v = 1024;
         5'd19: v = 512;
         5'd20: v = 256;
         5'd21: v = 128;
         5'd22: v = 64;
         5'd23: v = 32;
         5'd24: v = 16;
         5'd25: v = 8;
         5'd26: v = 4;
         5'd27: v = 2;
         default: v = 0;
      endcase
      return v;
   endfunction

   // Shift right with rounding to nearest, ties away from zero.
   function automatic logic signed [ProdW-1:0] rnd_shr(input logic signed [ProdW-1:0] v,
                                                      input int unsigned n);
      logic [ProdW-1:0] mag;
      logic [ProdW-1:0] half;
      mag = v[ProdW-1] ? (~v + ProdW'(1)) : v;
      half = ProdW'(1) << (n - 1);
      mag = (mag + half) >> n;
      return v[ProdW-1] ? signed'(~mag + ProdW'(1)) : signed'(mag);
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [PtW-1:0] v);
      logic signed [31:0] r;
      if (v > PtMax) begin
         r = PtMax[31:0];
      end else if (v < PtMin) begin
         r = PtMin[31:0];
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

[src/atcb_sincos.sv]
// Iterative sine and cosine unit: quarter-turn reduction followed by CORDIC rotation.
module atcb_sincos (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             go,
   input  logic signed [atcb_pkg::AngW-1:0] angle,
   output logic                             done,
   output logic signed [31:0]               cos_val,
   output logic signed [31:0]               sin_val
);
   import atcb_pkg::*;

   typedef enum logic [1:0] {SC_IDLE, SC_REDUCE, SC_ROTATE} sc_state_type;

   sc_state_type           state_ff, state_in;
   logic signed [RedW-1:0] ang_ff, ang_in;
   logic [1:0]             quad_ff, quad_in;
   logic signed [31:0]     x_ff, x_in, y_ff, y_in, r_ff, r_in;
   logic [4:0]             step_ff, step_in;
   logic                   done_ff, done_in;
   logic signed [31:0]     cos_ff, cos_in, sin_ff, sin_in;

   logic [3:0]             kcount;
   logic signed [RedW-1:0] kofs;
   logic signed [31:0]     dx, dy;

   always_comb begin
      state_in = state_ff;
      ang_in   = ang_ff;
      quad_in  = quad_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      r_in     = r_ff;
      step_in  = step_ff;
      done_in  = 1'b0;
      cos_in   = cos_ff;
      sin_in   = sin_ff;
      kcount   = '0;
      for (int j = 0; j < RedSpan; j++) begin
         if (ang_ff >= RedW'(QTurnLong * longint'(j + RedKMin + 1)
                             - longint'(QTurnHalf))) begin
            kcount = kcount + 4'd1;
         end
      end
      kofs = '0;
      for (int j = 0; j <= RedSpan; j++) begin
         if (kcount == 4'(j)) begin
            kofs = RedW'(QTurnLong * longint'(j + RedKMin));
         end
      end
      dx       = y_ff >>> step_ff;
      dy       = x_ff >>> step_ff;
      unique case (state_ff)
         SC_IDLE: begin
            if (go) begin
               ang_in = RedW'(angle);
               state_in = SC_REDUCE;
            end
         end
         SC_REDUCE: begin
            quad_in = 2'(kcount) + 2'(RedKMin);
            r_in = 32'(ang_ff - kofs);
            x_in = CordicInit;
            y_in = '0;
            step_in = '0;
            state_in = SC_ROTATE;
         end
         SC_ROTATE: begin
            if (!r_ff[31]) begin
               x_in = x_ff - dx;
               y_in = y_ff + dy;
               r_in = r_ff - atan_tab(step_ff);
            end else begin
               x_in = x_ff + dx;
               y_in = y_ff - dy;
               r_in = r_ff + atan_tab(step_ff);
            end
            step_in = step_ff + 5'd1;
            if (step_ff == 5'(CordicSteps - 1)) begin
               unique case (quad_ff)
                  2'd0: begin cos_in = x_in;  sin_in = y_in;  end
                  2'd1: begin cos_in = -y_in; sin_in = x_in;  end
                  2'd2: begin cos_in = -x_in; sin_in = -y_in; end
                  2'd3: begin cos_in = y_in;  sin_in = -x_in; end
               endcase
               done_in = 1'b1;
               state_in = SC_IDLE;
            end
         end
         default: state_in = SC_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SC_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      ang_ff  <= ang_in;
      quad_ff <= quad_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      r_ff    <= r_in;
      step_ff <= step_in;
      cos_ff  <= cos_in;
      sin_ff  <= sin_in;
   end

   assign done    = done_ff;
   assign cos_val = cos_ff;
   assign sin_val = sin_ff;

endmodule

[src/atcb_divider.sv]
// Restoring divider for the control distance sin * 2^30 / (3 * cos), saturated.
module atcb_divider (
   input  logic               clock,
   input  logic               reset,
   input  logic               go,
   input  logic signed [31:0] num,
   input  logic signed [31:0] den,
   output logic               done,
   output logic signed [31:0] quot
);
   import atcb_pkg::*;

   typedef enum logic {DV_IDLE, DV_RUN} dv_state_type;

   dv_state_type       state_ff, state_in;
   logic [DivRemW-1:0] rem_ff, rem_in;
   logic [DivDenW-1:0] den_ff, den_in;
   logic [31:0]        q_ff, q_in;
   logic [4:0]         bit_ff, bit_in;
   logic               neg_ff, neg_in;
   logic               done_ff, done_in;
   logic signed [31:0] quot_ff, quot_in;

   logic [32:0]        num_mag, den_mag;
   logic [DivRemW-1:0] shifted;
   logic signed [31:0] mag;

   always_comb begin
      state_in = state_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      q_in     = q_ff;
      bit_in   = bit_ff;
      neg_in   = neg_ff;
      done_in  = 1'b0;
      quot_in  = quot_ff;
      num_mag  = num[31] ? (~{1'b1, num} + 33'd1) : {1'b0, num};
      den_mag  = den[31] ? (~{1'b1, den} + 33'd1) : {1'b0, den};
      shifted  = DivRemW'(den_ff) << bit_ff;
      mag      = '0;
      unique case (state_ff)
         DV_IDLE: begin
            if (go) begin
               if (den == '0) begin
                  if (num == '0) begin
                     quot_in = '0;
                  end else if (num[31]) begin
                     quot_in = -DistLimit;
                  end else begin
                     quot_in = DistLimit;
                  end
                  done_in = 1'b1;
               end else begin
                  rem_in = DivRemW'(num_mag) << 30;
                  den_in = DivDenW'(den_mag) + (DivDenW'(den_mag) << 1);
                  neg_in = num[31] ^ den[31];
                  q_in = '0;
                  bit_in = 5'd31;
                  state_in = DV_RUN;
               end
            end
         end
         DV_RUN: begin
            if (rem_ff >= shifted) begin
               rem_in = rem_ff - shifted;
               q_in[bit_ff] = 1'b1;
            end
            if (bit_ff == 5'd0) begin
               mag = q_in[31] ? DistLimit : signed'({1'b0, q_in[30:0]});
               quot_in = neg_ff ? -mag : mag;
               done_in = 1'b1;
               state_in = DV_IDLE;
            end else begin
               bit_in = bit_ff - 5'd1;
            end
         end
         default: state_in = DV_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DV_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      q_ff    <= q_in;
      bit_ff  <= bit_in;
      neg_ff  <= neg_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

[src/atcb_datapath.sv]
// Datapath: arc operands, shared multiplier, point accumulators and result registers.
module atcb_datapath (
   input  logic                       clock,
   input  logic                       reset,
   input  atcb_pkg::cmd_type          cmd,
   output atcb_pkg::status_type       status,
   input  logic signed [31:0]         center_x,
   input  logic signed [31:0]         center_y,
   input  logic [30:0]                radius_horizontal,
   input  logic [30:0]                radius_vertical,
   input  logic signed [31:0]         angle_begin,
   input  logic signed [31:0]         angle_finish,
   output logic signed [31:0]         seg_start_x,
   output logic signed [31:0]         seg_start_y,
   output logic signed [31:0]         first_ctrl_x,
   output logic signed [31:0]         first_ctrl_y,
   output logic signed [31:0]         second_ctrl_x,
   output logic signed [31:0]         second_ctrl_y,
   output logic signed [31:0]         seg_end_x,
   output logic signed [31:0]         seg_end_y
);
   import atcb_pkg::*;

   logic signed [31:0]      cx_ff, cx_in, cy_ff, cy_in;
   logic [30:0]             rx_ff, rx_in, ry_ff, ry_in;
   logic signed [AngW-1:0]  a1_ff, a1_in, s_ff, s_in, e_ff, e_in;
   logic signed [ProdW-1:0] prod_ff, prod_in;
   logic signed [MulW-1:0]  tmp_ff, tmp_in;
   logic signed [PtW-1:0]   xa_ff, xa_in, ya_ff, ya_in, xb_ff, xb_in, yb_ff, yb_in;
   logic signed [31:0]      p0x_ff, p0x_in, p0y_ff, p0y_in, p1x_ff, p1x_in, p1y_ff, p1y_in;
   logic signed [31:0]      p2x_ff, p2x_in, p2y_ff, p2y_in, p3x_ff, p3x_in, p3y_ff, p3y_in;

   logic                    sc_go, sc_done, div_done;
   logic signed [AngW-1:0]  sc_angle;
   logic signed [31:0]      cs, sn, ctrl_dist;
   logic signed [AngW-1:0]  sweep, qsweep, base, stepped, e_next;
   logic signed [MulW-1:0]  mul_a, mul_b;
   logic signed [ProdW-1:0] r30, r28;

   atcb_sincos u_sincos (
      .clock   (clock),
      .reset   (reset),
      .go      (sc_go),
      .angle   (sc_angle),
      .done    (sc_done),
      .cos_val (cs),
      .sin_val (sn)
   );

   atcb_divider u_divider (
      .clock (clock),
      .reset (reset),
      .go    (cmd.op == OP_DIST),
      .num   (sn),
      .den   (cs),
      .done  (div_done),
      .quot  (ctrl_dist)
   );

   always_comb begin
      sweep  = e_ff - s_ff;
      qsweep = AngW'(rnd_shr(ProdW'(sweep), 2));
      sc_go  = (cmd.op == OP_SC_SWEEP) || (cmd.op == OP_SC_S) || (cmd.op == OP_SC_E);
      unique case (cmd.op)
         OP_SC_SWEEP: sc_angle = qsweep;
         OP_SC_E:     sc_angle = e_ff;
         default:     sc_angle = s_ff;
      endcase
      base = (cmd.op == OP_LOAD) ? AngW'(angle_begin) : e_ff;
      stepped = base + QTurn;
      e_next = (((cmd.op == OP_LOAD) ? AngW'(angle_finish) : a1_ff) < stepped)
               ? ((cmd.op == OP_LOAD) ? AngW'(angle_finish) : a1_ff) : stepped;
      unique case (cmd.op)
         OP_MUL_CRX: begin mul_a = MulW'(cs);     mul_b = MulW'({1'b0, rx_ff}); end
         OP_MUL_SRY: begin mul_a = MulW'(sn);     mul_b = MulW'({1'b0, ry_ff}); end
         OP_MUL_SD:  begin mul_a = MulW'(sn);     mul_b = MulW'(ctrl_dist);     end
         OP_MUL_CD:  begin mul_a = MulW'(cs);     mul_b = MulW'(ctrl_dist);     end
         OP_MUL_TRX: begin mul_a = tmp_ff;        mul_b = MulW'({1'b0, rx_ff}); end
         default:    begin mul_a = tmp_ff;        mul_b = MulW'({1'b0, ry_ff}); end
      endcase
      r30 = rnd_shr(prod_ff, 30);
      r28 = rnd_shr(prod_ff, 28);
   end

   always_comb begin
      cx_in = cx_ff; cy_in = cy_ff; rx_in = rx_ff; ry_in = ry_ff;
      a1_in = a1_ff; s_in = s_ff; e_in = e_ff;
      prod_in = prod_ff; tmp_in = tmp_ff;
      xa_in = xa_ff; ya_in = ya_ff; xb_in = xb_ff; yb_in = yb_ff;
      p0x_in = p0x_ff; p0y_in = p0y_ff; p1x_in = p1x_ff; p1y_in = p1y_ff;
      p2x_in = p2x_ff; p2y_in = p2y_ff; p3x_in = p3x_ff; p3y_in = p3y_ff;
      unique case (cmd.op)
         OP_LOAD: begin
            cx_in = center_x;
            cy_in = center_y;
            rx_in = radius_horizontal;
            ry_in = radius_vertical;
            a1_in = AngW'(angle_finish);
            s_in  = AngW'(angle_begin);
            e_in  = e_next;
         end
         OP_ADVANCE: begin
            s_in = e_ff;
            e_in = e_next;
         end
         OP_MUL_CRX, OP_MUL_SRY, OP_MUL_SD, OP_MUL_CD, OP_MUL_TRX, OP_MUL_TRY: begin
            prod_in = mul_a * mul_b;
         end
         OP_SET_XA:  xa_in = PtW'(cx_ff) + PtW'(r30);
         OP_SET_YA:  ya_in = PtW'(cy_ff) + PtW'(r30);
         OP_SET_TMP: tmp_in = MulW'(r30);
         OP_ADJ_X:   xb_in = cmd.phase_end ? (xa_ff + PtW'(r28)) : (xa_ff - PtW'(r28));
         OP_ADJ_Y:   yb_in = cmd.phase_end ? (ya_ff - PtW'(r28)) : (ya_ff + PtW'(r28));
         OP_STORE_START: begin
            p0x_in = sat32(xa_ff);
            p0y_in = sat32(ya_ff);
            p1x_in = sat32(xb_ff);
            p1y_in = sat32(yb_ff);
         end
         OP_STORE_END: begin
            p3x_in = sat32(xa_ff);
            p3y_in = sat32(ya_ff);
            p2x_in = sat32(xb_ff);
            p2y_in = sat32(yb_ff);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      cx_ff <= cx_in; cy_ff <= cy_in; rx_ff <= rx_in; ry_ff <= ry_in;
      a1_ff <= a1_in; s_ff <= s_in; e_ff <= e_in;
      prod_ff <= prod_in; tmp_ff <= tmp_in;
      xa_ff <= xa_in; ya_ff <= ya_in; xb_ff <= xb_in; yb_ff <= yb_in;
      p0x_ff <= p0x_in; p0y_ff <= p0y_in; p1x_ff <= p1x_in; p1y_ff <= p1y_in;
      p2x_ff <= p2x_in; p2y_ff <= p2y_in; p3x_ff <= p3x_in; p3y_ff <= p3y_in;
   end

   assign status.sc_done  = sc_done;
   assign status.div_done = div_done;
   assign status.fin      = (e_ff == a1_ff);

   assign seg_start_x   = p0x_ff;
   assign seg_start_y   = p0y_ff;
   assign first_ctrl_x  = p1x_ff;
   assign first_ctrl_y  = p1y_ff;
   assign second_ctrl_x = p2x_ff;
   assign second_ctrl_y = p2y_ff;
   assign seg_end_x     = p3x_ff;
   assign seg_end_y     = p3y_ff;

endmodule

[src/atcb_control.sv]
// Controller state machine that sequences the datapath through each segment.
module atcb_control (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   output atcb_pkg::cmd_type    cmd,
   input  atcb_pkg::status_type status,
   output logic                 rsp_valid,
   output logic [1:0]           rsp_segment_number,
   output logic                 rsp_last
);
   import atcb_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE, ST_SC_SWEEP, ST_WAIT_SWEEP, ST_DIST, ST_WAIT_DIST, ST_SC_POINT,
      ST_WAIT_POINT, ST_MUL_CRX, ST_SET_XA, ST_MUL_SRY, ST_SET_YA, ST_MUL_SD,
      ST_TMP_S, ST_MUL_TRX, ST_ADJ_X, ST_MUL_CD, ST_TMP_C, ST_MUL_TRY, ST_ADJ_Y,
      ST_STORE, ST_ADVANCE
   } state_type;

   state_type       state_ff;
   logic            phase_ff;
   logic [SegW-1:0] seg_ff, segnum_ff;
   logic            valid_ff, last_ff;
   logic            fin_all;
   logic [SegW+1:0] seg_wide;

   assign fin_all = status.fin || (seg_ff == SegW'(MaxSegments - 1));

   always_comb begin
      cmd.phase_end = phase_ff;
      unique case (state_ff)
         ST_IDLE:     cmd.op = start ? OP_LOAD : OP_NONE;
         ST_SC_SWEEP: cmd.op = OP_SC_SWEEP;
         ST_DIST:     cmd.op = OP_DIST;
         ST_SC_POINT: cmd.op = phase_ff ? OP_SC_E : OP_SC_S;
         ST_MUL_CRX:  cmd.op = OP_MUL_CRX;
         ST_SET_XA:   cmd.op = OP_SET_XA;
         ST_MUL_SRY:  cmd.op = OP_MUL_SRY;
         ST_SET_YA:   cmd.op = OP_SET_YA;
         ST_MUL_SD:   cmd.op = OP_MUL_SD;
         ST_TMP_S:    cmd.op = OP_SET_TMP;
         ST_MUL_TRX:  cmd.op = OP_MUL_TRX;
         ST_ADJ_X:    cmd.op = OP_ADJ_X;
         ST_MUL_CD:   cmd.op = OP_MUL_CD;
         ST_TMP_C:    cmd.op = OP_SET_TMP;
         ST_MUL_TRY:  cmd.op = OP_MUL_TRY;
         ST_ADJ_Y:    cmd.op = OP_ADJ_Y;
         ST_STORE:    cmd.op = phase_ff ? OP_STORE_END : OP_STORE_START;
         ST_ADVANCE:  cmd.op = OP_ADVANCE;
         default:     cmd.op = OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= 1'b0;
         seg_ff   <= '0;
         valid_ff <= 1'b0;
         last_ff  <= 1'b0;
         segnum_ff <= '0;
      end else begin
         valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  seg_ff   <= '0;
                  phase_ff <= 1'b0;
                  state_ff <= ST_SC_SWEEP;
               end
            end
            ST_SC_SWEEP:   state_ff <= ST_WAIT_SWEEP;
            ST_WAIT_SWEEP: if (status.sc_done) state_ff <= ST_DIST;
            ST_DIST:       state_ff <= ST_WAIT_DIST;
            ST_WAIT_DIST:  if (status.div_done) state_ff <= ST_SC_POINT;
            ST_SC_POINT:   state_ff <= ST_WAIT_POINT;
            ST_WAIT_POINT: if (status.sc_done) state_ff <= ST_MUL_CRX;
            ST_MUL_CRX:    state_ff <= ST_SET_XA;
            ST_SET_XA:     state_ff <= ST_MUL_SRY;
            ST_MUL_SRY:    state_ff <= ST_SET_YA;
            ST_SET_YA:     state_ff <= ST_MUL_SD;
            ST_MUL_SD:     state_ff <= ST_TMP_S;
            ST_TMP_S:      state_ff <= ST_MUL_TRX;
            ST_MUL_TRX:    state_ff <= ST_ADJ_X;
            ST_ADJ_X:      state_ff <= ST_MUL_CD;
            ST_MUL_CD:     state_ff <= ST_TMP_C;
            ST_TMP_C:      state_ff <= ST_MUL_TRY;
            ST_MUL_TRY:    state_ff <= ST_ADJ_Y;
            ST_ADJ_Y:      state_ff <= ST_STORE;
            ST_STORE: begin
               if (!phase_ff) begin
                  phase_ff <= 1'b1;
                  state_ff <= ST_SC_POINT;
               end else begin
                  valid_ff  <= 1'b1;
                  last_ff   <= fin_all;
                  segnum_ff <= seg_ff;
                  state_ff  <= fin_all ? ST_IDLE : ST_ADVANCE;
               end
            end
            ST_ADVANCE: begin
               seg_ff   <= seg_ff + SegW'(1);
               phase_ff <= 1'b0;
               state_ff <= ST_SC_SWEEP;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign seg_wide           = {2'b00, segnum_ff};
   assign busy               = (state_ff != ST_IDLE);
   assign rsp_valid          = valid_ff;
   assign rsp_last           = last_ff;
   assign rsp_segment_number = seg_wide[1:0];

endmodule

[src/arc_to_cubic_bezier.sv]
// Top level of the elliptical arc to cubic Bezier segment generator.
// A request is taken at a rising clock edge where start is high and busy is low.
// It carries the arc center, the two radii and the start and finish angles.
// The arc is cut into pieces of at most a quarter turn, and for each piece one
// result is shown for exactly one cycle with rsp_valid high: four points, the
// segment number and rsp_last on the final segment of the arc.
// Each segment runs three sine and cosine evaluations on one shared CORDIC unit
// (issue, angle reduction, rotation and collection), one 32-step division for
// the control distance (bypassed when the cosine of a quarter of the sweep is
// zero) and the multiply and accumulate steps on one shared multiplier.
// busy stays high until the last result is shown; it is low in the cycle that
// shows it, and a new request can be taken in that cycle.
// Results cannot be held off by the receiver and are never dropped.
// Synchronous reset returns the controller and both arithmetic units to idle.
module arc_to_cubic_bezier (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_center_x,
   input  logic signed [31:0] req_center_y,
   input  logic [30:0]        req_radius_horizontal,
   input  logic [30:0]        req_radius_vertical,
   input  logic signed [31:0] req_angle_begin,
   input  logic signed [31:0] req_angle_finish,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_seg_start_x,
   output logic signed [31:0] rsp_seg_start_y,
   output logic signed [31:0] rsp_first_ctrl_x,
   output logic signed [31:0] rsp_first_ctrl_y,
   output logic signed [31:0] rsp_second_ctrl_x,
   output logic signed [31:0] rsp_second_ctrl_y,
   output logic signed [31:0] rsp_seg_end_x,
   output logic signed [31:0] rsp_seg_end_y,
   output logic [1:0]         rsp_segment_number,
   output logic               rsp_last
);
   import atcb_pkg::*;

   cmd_type    cmd;
   status_type status;

   atcb_control u_control (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .cmd                (cmd),
      .status             (status),
      .rsp_valid          (rsp_valid),
      .rsp_segment_number (rsp_segment_number),
      .rsp_last           (rsp_last)
   );

   atcb_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .center_x          (req_center_x),
      .center_y          (req_center_y),
      .radius_horizontal (req_radius_horizontal),
      .radius_vertical   (req_radius_vertical),
      .angle_begin       (req_angle_begin),
      .angle_finish      (req_angle_finish),
      .seg_start_x       (rsp_seg_start_x),
      .seg_start_y       (rsp_seg_start_y),
      .first_ctrl_x      (rsp_first_ctrl_x),
      .first_ctrl_y      (rsp_first_ctrl_y),
      .second_ctrl_x     (rsp_second_ctrl_x),
      .second_ctrl_y     (rsp_second_ctrl_y),
      .seg_end_x         (rsp_seg_end_x),
      .seg_end_y         (rsp_seg_end_y)
   );

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted request did not make the block busy");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> !busy)
      else $error("block still busy on the final segment");

   a_more_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> busy)
      else $error("block went idle before the final segment");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe lasted more than one cycle");

endmodule

[test/arc_to_cubic_bezier_checker.sv]
// Checker that predicts the Bezier segments of each arc request and compares them.
module arc_to_cubic_bezier_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic signed [31:0] req_center_x,
   input  logic signed [31:0] req_center_y,
   input  logic [30:0]        req_radius_horizontal,
   input  logic [30:0]        req_radius_vertical,
   input  logic signed [31:0] req_angle_begin,
   input  logic signed [31:0] req_angle_finish,
   input  logic               rsp_valid,
   input  logic signed [31:0] rsp_seg_start_x,
   input  logic signed [31:0] rsp_seg_start_y,
   input  logic signed [31:0] rsp_first_ctrl_x,
   input  logic signed [31:0] rsp_first_ctrl_y,
   input  logic signed [31:0] rsp_second_ctrl_x,
   input  logic signed [31:0] rsp_second_ctrl_y,
   input  logic signed [31:0] rsp_seg_end_x,
   input  logic signed [31:0] rsp_seg_end_y,
   input  logic [1:0]         rsp_segment_number,
   input  logic               rsp_last,
   output int                 error_count,
   output int                 pending_count,
   output int                 segment_count,
   output int                 arc_count
);
   import atcb_pkg::*;

   typedef struct packed {
      logic signed [31:0] x0, y0, x1, y1, x2, y2, x3, y3;
      logic [1:0]         num;
      logic               fin;
   } segment_type;

   localparam longint QuarterTurn = 421657428;

   segment_type segment_queue[$];
   longint      arctan_table[28];

   function automatic longint shr_round(longint v, int n);
      longint m;
      m = (v < 0) ? -v : v;
      m = (m + (longint'(1) << (n - 1))) >>> n;
      return (v < 0) ? -m : m;
   endfunction

   function automatic longint shr_floor(longint v, int n);
      return v >>> n;
   endfunction

   function automatic longint sat_word(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   task automatic cordic_sin_cos(input longint ang, output longint cs, output longint sn);
      longint t, k, r, x, y, dx, dy;
      t = ang + QuarterTurn / 2;
      k = (t >= 0) ? t / QuarterTurn : -((-t + QuarterTurn - 1) / QuarterTurn);
      r = ang - k * QuarterTurn;
      x = 652032874;
      y = 0;
      for (int i = 0; i < 28; i++) begin
         dx = shr_floor(y, i);
         dy = shr_floor(x, i);
         if (r >= 0) begin
            x -= dx; y += dy; r -= arctan_table[i];
         end else begin
            x += dx; y -= dy; r += arctan_table[i];
         end
      end
      case (k & 3)
         0: begin cs = x; sn = y; end
         1: begin cs = -y; sn = x; end
         2: begin cs = -x; sn = -y; end
         default: begin cs = y; sn = -x; end
      endcase
   endtask

   task automatic tangent_distance(input longint sweep, output longint d);
      longint c, s;
      cordic_sin_cos(shr_round(sweep, 2), c, s);
      if (c == 0) begin
         d = (s > 0) ? 2147483647 : (s < 0) ? -2147483647 : 0;
      end else begin
         d = (s * (longint'(1) << 30)) / (3 * c);
         if (d > 2147483647) d = 2147483647;
         if (d < -2147483647) d = -2147483647;
      end
   endtask

   task automatic predict_arc();
      longint cx, cy, rx, ry, a1, s, e, d, cu, sv;
      longint x0, y0, x1, y1, x2, y2, x3, y3;
      segment_type seg;
      cx = req_center_x;
      cy = req_center_y;
      rx = req_radius_horizontal;
      ry = req_radius_vertical;
      a1 = req_angle_finish;
      s = req_angle_begin;
      e = (a1 < s + QuarterTurn) ? a1 : s + QuarterTurn;
      for (int i = 0; i < MaxSegments; i++) begin
         tangent_distance(e - s, d);
         cordic_sin_cos(s, cu, sv);
         x0 = cx + shr_round(cu * rx, 30);
         y0 = cy + shr_round(sv * ry, 30);
         x1 = x0 - shr_round(shr_round(sv * d, 30) * rx, 28);
         y1 = y0 + shr_round(shr_round(cu * d, 30) * ry, 28);
         cordic_sin_cos(e, cu, sv);
         x3 = cx + shr_round(cu * rx, 30);
         y3 = cy + shr_round(sv * ry, 30);
         x2 = x3 + shr_round(shr_round(sv * d, 30) * rx, 28);
         y2 = y3 - shr_round(shr_round(cu * d, 30) * ry, 28);
         seg.x0 = 32'(sat_word(x0)); seg.y0 = 32'(sat_word(y0));
         seg.x1 = 32'(sat_word(x1)); seg.y1 = 32'(sat_word(y1));
         seg.x2 = 32'(sat_word(x2)); seg.y2 = 32'(sat_word(y2));
         seg.x3 = 32'(sat_word(x3)); seg.y3 = 32'(sat_word(y3));
         seg.num = i[1:0];
         seg.fin = (e == a1) || (i == MaxSegments - 1);
         segment_queue = {segment_queue, seg};
         if (seg.fin) break;
         s = e;
         e = (a1 < s + QuarterTurn) ? a1 : s + QuarterTurn;
      end
   endtask

   task automatic compare_field(string name, longint want, longint got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   initial begin
      longint sum, term;
      int ex;
      error_count = 0;
      pending_count = 0;
      segment_count = 0;
      arc_count = 0;
      arctan_table[0] = 210828714;
      for (int i = 1; i < 28; i++) begin
         sum = 0;
         for (int n = 0; ; n++) begin
            ex = i * (2 * n + 1);
            if (ex > 60) break;
            term = (longint'(1) << (60 - ex)) / (2 * n + 1);
            sum = (n & 1) ? sum - term : sum + term;
         end
         arctan_table[i] = shr_round(sum, 32);
      end
   end

   always @(posedge clock) begin
      segment_type w;
      if (!reset && start && !busy) begin
         predict_arc();
         arc_count++;
      end
      if (!reset && rsp_valid) begin
         segment_count++;
         if (segment_queue.size() == 0) begin
            $error("segment arrived with no request outstanding");
            error_count++;
         end else begin
            w = segment_queue.pop_front();
            compare_field("seg_start_x", w.x0, rsp_seg_start_x);
            compare_field("seg_start_y", w.y0, rsp_seg_start_y);
            compare_field("first_ctrl_x", w.x1, rsp_first_ctrl_x);
            compare_field("first_ctrl_y", w.y1, rsp_first_ctrl_y);
            compare_field("second_ctrl_x", w.x2, rsp_second_ctrl_x);
            compare_field("second_ctrl_y", w.y2, rsp_second_ctrl_y);
            compare_field("seg_end_x", w.x3, rsp_seg_end_x);
            compare_field("seg_end_y", w.y3, rsp_seg_end_y);
            compare_field("segment_number", w.num, rsp_segment_number);
            compare_field("last", w.fin, rsp_last);
         end
      end
      pending_count = segment_queue.size();
   end
endmodule

[test/tb_arc_to_cubic_bezier.sv]
// Testbench top for the arc to cubic Bezier block: stimulus, clock, reset and verdict.
module tb_arc_to_cubic_bezier;
   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic signed [31:0] req_center_x, req_center_y, req_angle_begin, req_angle_finish;
   logic [30:0]        req_radius_horizontal, req_radius_vertical;
   logic               rsp_valid;
   logic signed [31:0] rsp_seg_start_x, rsp_seg_start_y, rsp_first_ctrl_x, rsp_first_ctrl_y;
   logic signed [31:0] rsp_second_ctrl_x, rsp_second_ctrl_y, rsp_seg_end_x, rsp_seg_end_y;
   logic [1:0]         rsp_segment_number;
   logic               rsp_last;
   int                 error_count, pending_count, segment_count, arc_count;
   longint             cycle_count;

   localparam int QTurnInt = 421657428;
   localparam longint CycleLimit = 3000000;

   arc_to_cubic_bezier dut (.*);
   arc_to_cubic_bezier_checker checker_inst (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CycleLimit) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   task automatic send_arc(logic [31:0] cx, logic [31:0] cy, logic [30:0] rx,
                           logic [30:0] ry, logic [31:0] a0, logic [31:0] a1);
      start <= 1'b1;
      req_center_x <= cx;
      req_center_y <= cy;
      req_radius_horizontal <= rx;
      req_radius_vertical <= ry;
      req_angle_begin <= a0;
      req_angle_finish <= a1;
      do @(posedge clock); while (busy);
   endtask

   task automatic idle_burst(int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic send_random_arc(int idx);
      logic [31:0] cx, cy, a0, a1;
      logic [30:0] rx, ry;
      int kind;
      kind = $urandom_range(0, 9);
      cx = (kind == 0) ? $urandom : $signed($urandom_range(0, 1 << 25)) - (1 << 24);
      cy = (kind == 1) ? $urandom : $signed($urandom_range(0, 1 << 25)) - (1 << 24);
      rx = (kind == 2) ? 31'($urandom) : 31'($urandom_range(0, 1 << 24));
      ry = (kind == 3) ? 31'($urandom) : 31'($urandom_range(0, 1 << 24));
      a0 = (kind == 4) ? $urandom : $signed($urandom_range(0, 1 << 31)) - (1 << 30);
      case ($urandom_range(0, 5))
         0: a1 = $urandom;
         1: a1 = a0 - $urandom_range(0, QTurnInt);
         2: a1 = a0 + QTurnInt * $urandom_range(0, 5);
         default: a1 = a0 + $urandom_range(0, 5 * QTurnInt);
      endcase
      send_arc(cx, cy, rx, ry, a0, a1);
      if (idx < 300 && $urandom_range(0, 2) == 0) idle_burst($urandom_range(1, 13));
   endtask

   initial begin
      start = 0;
      req_center_x = 0;
      req_center_y = 0;
      req_radius_horizontal = 0;
      req_radius_vertical = 0;
      req_angle_begin = 0;
      req_angle_finish = 0;
      reset = 1;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_arc(0, 0, 31'h10000, 31'h10000, 0, QTurnInt);
      send_arc(0, 0, 31'h10000, 31'h20000, 0, 2 * QTurnInt);
      send_arc(32'h100, 32'h200, 31'h10000, 31'h10000, QTurnInt, 0);
      send_arc(5, -5, 31'h30000, 31'h10000, 12345, 12345);
      send_arc(0, 0, 31'h7fffffff, 31'h7fffffff, 0, 32'h7fffffff);
      send_arc(32'h7fffffff, 32'h7fffffff, 31'h7fffffff, 31'h7fffffff, 0, QTurnInt / 2);
      send_arc(32'h80000000, 32'h80000000, 31'h7fffffff, 31'h7fffffff,
               2 * QTurnInt, 3 * QTurnInt);
      send_arc(32'hffffffff, 32'h80000000, 31'd0, 31'd0, 32'h80000000, 32'h7fffffff);
      send_arc(0, 0, 31'h10000, 31'h10000, 32'h7fffffff, 32'h80000000);
      send_arc(0, 0, 31'h10000, 31'h10000, 0, 4 * QTurnInt);
      send_arc(0, 0, 31'h10000, 31'h10000, -2 * QTurnInt, 2 * QTurnInt);
      send_arc(0, 0, 31'h10000, 31'h10000, 0, 8 * QTurnInt);
      send_arc(0, 0, 31'h10000, 31'h10000, 0, 1);
      send_arc(0, 0, 31'h10000, 31'h10000, 0, -1);
      send_arc(32'h55555555, 32'haaaaaaaa, 31'h2aaaaaaa, 31'h55555555,
               32'h55555555, 32'haaaaaaaa);
      for (int i = 0; i < 345; i++) send_random_arc(i);
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      $display("Covered %0d arcs producing %0d Bezier segments.", arc_count, segment_count);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
